// ----- rtl/core/mtep_pkg.sv -----
// Shared types and constants for the MIDI track event parser.
// Used by mtep_front, mtep_back and midi_track_event_parser; no dependencies.
package mtep_pkg;

   localparam int TICK_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [7:0] META_PREFIX = 8'hFF;
   localparam logic [7:0] META_EOT    = 8'h2F;
   localparam logic [7:0] META_TEMPO  = 8'h51;
   localparam logic [2:0] CLASS_ONE_DATA = 3'b110; // C0 and D0 status classes
   localparam logic [3:0] SYSTEM_NIBBLE  = 4'hF;

   typedef enum logic [3:0] {
      PH_DELTA     = 4'd0,
      PH_STATUS    = 4'd1,
      PH_DATA1     = 4'd2,
      PH_DATA2     = 4'd3,
      PH_META_TYPE = 4'd4,
      PH_META_LEN  = 4'd5,
      PH_SYSEX_LEN = 4'd6,
      PH_SKIP      = 4'd7,
      PH_TEMPO     = 4'd8,
      PH_DONE      = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHANNEL = 2'd0,
      KIND_TEMPO   = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   // classified input byte, as queued between front and back
   typedef struct packed {
      logic [7:0] data;
      logic       track_start;
      logic       is_status;     // top bit set
      logic       is_system;     // F0..FF
      logic       is_meta;       // FF
      logic       is_eot_type;   // 2F
      logic       is_tempo_type; // 51
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic [23:0] tempo_us;
      logic [31:0] event_tick;
      logic [7:0]  second_data;
      logic [7:0]  first_data;
      logic [7:0]  status_byte;
      kind_type    event_kind;
   } result_type;

endpackage

// ----- rtl/core/mtep_front.sv -----
// Front end: accepts track bytes, classifies them and holds them in a short queue.
// Depends on mtep_pkg.
module mtep_front
   import mtep_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_data,
   input  logic          req_start,
   input  logic          pop,
   output queue_out_type head
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type             slot_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   item_type             classified;
   logic                 push;
   logic                 do_pop;

   always_comb begin
      classified.data          = req_data;
      classified.track_start   = req_start;
      classified.is_status     = req_data[7];
      classified.is_system     = (req_data[7:4] == SYSTEM_NIBBLE);
      classified.is_meta       = (req_data == META_PREFIX);
      classified.is_eot_type   = (req_data == META_EOT);
      classified.is_tempo_type = (req_data == META_TEMPO);
   end

   assign req_tready = (count_ff != FULL_CNT);
   assign push       = req_tvalid && req_tready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ----- rtl/core/mtep_back.sv -----
// Back end: parse state machine over queued bytes, with the result register.
// Depends on mtep_pkg.
module mtep_back
   import mtep_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type head,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output result_type    rsp_result
);

   localparam int EXT_W = (TICK_BITS > 32) ? TICK_BITS : 32;
   localparam int SUM_W = EXT_W + 1;

   phase_type            phase_ff, phase_in;
   logic [7:0]           run_status_ff, run_status_in;
   logic [7:0]           cur_status_ff, cur_status_in;
   logic [7:0]           held_ff, held_in;
   logic [31:0]          quantity_ff, quantity_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [31:0]          skip_ff, skip_in;
   logic                 meta_eot_ff, meta_eot_in;
   logic                 meta_tempo_ff, meta_tempo_in;
   logic [23:0]          tempo_ff, tempo_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;

   // state as seen by this byte: a track start restarts everything first
   phase_type            e_phase;
   logic [7:0]           e_run_status, e_cur_status, e_held;
   logic [31:0]          e_quantity, e_skip, q_next, skip_dec;
   logic [TICK_BITS-1:0] e_tick;
   logic                 e_meta_eot, e_meta_tempo;
   logic [23:0]          e_tempo, tempo_next;
   logic [SUM_W-1:0]     tick_sum;
   logic [EXT_W-1:0]     tick_ext;
   logic [7:0]           b;
   logic                 fire;
   logic                 emit;
   result_type           res;

   assign pop        = head.valid && (!rsp_valid_ff || rsp_tready);
   assign fire       = pop;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   always_comb begin
      b            = head.item.data;
      e_phase      = head.item.track_start ? PH_DELTA : phase_ff;
      e_run_status = head.item.track_start ? 8'h00 : run_status_ff;
      e_cur_status = head.item.track_start ? 8'h00 : cur_status_ff;
      e_held       = head.item.track_start ? 8'h00 : held_ff;
      e_quantity   = head.item.track_start ? 32'h0 : quantity_ff;
      e_tick       = head.item.track_start ? '0 : tick_ff;
      e_skip       = head.item.track_start ? 32'h0 : skip_ff;
      e_meta_eot   = head.item.track_start ? 1'b0 : meta_eot_ff;
      e_meta_tempo = head.item.track_start ? 1'b0 : meta_tempo_ff;
      e_tempo      = head.item.track_start ? 24'h0 : tempo_ff;

      q_next     = {e_quantity[24:0], b[6:0]};
      skip_dec   = e_skip - 32'd1;
      tempo_next = {e_tempo[15:0], b};
      tick_sum   = SUM_W'(e_tick) + SUM_W'(q_next);
      tick_ext   = EXT_W'(e_tick);

      phase_in      = e_phase;
      run_status_in = e_run_status;
      cur_status_in = e_cur_status;
      held_in       = e_held;
      quantity_in   = e_quantity;
      tick_in       = e_tick;
      skip_in       = e_skip;
      meta_eot_in   = e_meta_eot;
      meta_tempo_in = e_meta_tempo;
      tempo_in      = e_tempo;

      emit            = 1'b0;
      res.event_kind  = KIND_CHANNEL;
      res.status_byte = 8'h00;
      res.first_data  = 8'h00;
      res.second_data = 8'h00;
      res.event_tick  = tick_ext[31:0];
      res.tempo_us    = 24'h0;

      case (e_phase)
         PH_DELTA: begin
            if (head.item.is_status) begin
               quantity_in = q_next;
            end else begin
               // saturating add of the finished delta
               tick_in     = (|tick_sum[SUM_W-1:TICK_BITS]) ? '1 : tick_sum[TICK_BITS-1:0];
               quantity_in = 32'h0;
               phase_in    = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (!head.item.is_status) begin
               cur_status_in = e_run_status;
               held_in       = b;
               if (e_run_status[7:5] == CLASS_ONE_DATA) begin
                  emit            = 1'b1;
                  res.status_byte = e_run_status;
                  res.first_data  = b;
                  phase_in        = PH_DELTA;
               end else begin
                  phase_in = PH_DATA2;
               end
            end else begin
               quantity_in = 32'h0;
               if (!head.item.is_system) begin
                  run_status_in = b;
                  cur_status_in = b;
                  phase_in      = PH_DATA1;
               end else if (head.item.is_meta) begin
                  phase_in = PH_META_TYPE;
               end else begin
                  phase_in = PH_SYSEX_LEN;
               end
            end
         end
         PH_DATA1: begin
            held_in = b;
            if (e_cur_status[7:5] == CLASS_ONE_DATA) begin
               emit            = 1'b1;
               res.status_byte = e_cur_status;
               res.first_data  = b;
               phase_in        = PH_DELTA;
            end else begin
               phase_in = PH_DATA2;
            end
         end
         PH_DATA2: begin
            emit            = 1'b1;
            res.status_byte = e_cur_status;
            res.first_data  = e_held;
            res.second_data = b;
            phase_in        = PH_DELTA;
         end
         PH_META_TYPE: begin
            meta_eot_in   = head.item.is_eot_type;
            meta_tempo_in = head.item.is_tempo_type;
            quantity_in   = 32'h0;
            phase_in      = PH_META_LEN;
         end
         PH_META_LEN: begin
            quantity_in = q_next;
            if (!head.item.is_status) begin
               quantity_in = 32'h0;
               if (e_meta_eot) begin
                  emit           = 1'b1;
                  res.event_kind = KIND_END;
                  phase_in       = PH_DONE;
               end else if (e_meta_tempo && (q_next == 32'd3)) begin
                  tempo_in = 24'h0;
                  skip_in  = 32'd3;
                  phase_in = PH_TEMPO;
               end else begin
                  skip_in  = q_next;
                  phase_in = (q_next == 32'h0) ? PH_DELTA : PH_SKIP;
               end
            end
         end
         PH_SYSEX_LEN: begin
            quantity_in = q_next;
            if (!head.item.is_status) begin
               quantity_in = 32'h0;
               skip_in     = q_next;
               phase_in    = (q_next == 32'h0) ? PH_DELTA : PH_SKIP;
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 32'h0) begin
               phase_in = PH_DELTA;
            end
         end
         PH_TEMPO: begin
            tempo_in = tempo_next;
            skip_in  = skip_dec;
            if (skip_dec == 32'h0) begin
               emit           = 1'b1;
               res.event_kind = KIND_TEMPO;
               res.tempo_us   = tempo_next;
               phase_in       = PH_DELTA;
            end
         end
         default: begin
            // end of track: ignore bytes until the next track start
            phase_in = PH_DONE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DELTA;
         run_status_ff <= 8'h00;
         cur_status_ff <= 8'h00;
         held_ff       <= 8'h00;
         quantity_ff   <= 32'h0;
         tick_ff       <= '0;
         skip_ff       <= 32'h0;
         meta_eot_ff   <= 1'b0;
         meta_tempo_ff <= 1'b0;
         tempo_ff      <= 24'h0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff      <= phase_in;
            run_status_ff <= run_status_in;
            cur_status_ff <= cur_status_in;
            held_ff       <= held_in;
            quantity_ff   <= quantity_in;
            tick_ff       <= tick_in;
            skip_ff       <= skip_in;
            meta_eot_ff   <= meta_eot_in;
            meta_tempo_ff <= meta_tempo_in;
            tempo_ff      <= tempo_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ----- rtl/core/midi_track_event_parser.sv -----
// MIDI track event parser: one track byte per word, events out as words.
// A byte accepted into the queue is read straight through from the queue head, and the
// state machine registers the result.
// Throughput: one byte per cycle while the result register is empty or being taken.
// Reset clears the queue, the parse state and the result valid flag; no clearing pass.
// Depends on mtep_pkg, mtep_front and mtep_back.
module midi_track_event_parser
   import mtep_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] track_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] status_byte, [15:8] first_data, [23:16] second_data,
   // [55:24] event_tick, [79:56] tempo_us
   output logic [79:0] rsp_tdata,
   output logic [1:0]  rsp_tuser    // [1:0] event_kind
);

   queue_out_type head;
   logic          pop;
   result_type    result;

   mtep_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_tdata),
      .req_start  (req_tuser),
      .pop        (pop),
      .head       (head)
   );

   mtep_back #(
      .TICK_BITS (TICK_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {result.tempo_us, result.event_tick, result.second_data,
                       result.first_data, result.status_byte};
   assign rsp_tuser = result.event_kind;

endmodule
